[design/division_magic_number_generator_top_macros.svh]
// Assertion macros for the division magic-number generator.
// Used by division_magic_number_generator_top; expects clk_i and rst_ni in scope.
`ifndef DIVISION_MAGIC_NUMBER_GENERATOR_TOP_MACROS_SVH
`define DIVISION_MAGIC_NUMBER_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define MDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mdg_pkg.sv]
// Shared types and constants for the division magic-number generator.
// No dependencies; imported by mdg_lane and the top level.
`default_nettype none

package mdg_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DIV_W         = 32;  // divisor field
  localparam int MULT_W        = 32;  // multiplier field
  localparam int SHIFT_W       = 6;   // shift_amount field

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [DIV_W-1:0] divisor;
  } mdg_in_t;

  typedef struct packed {
    logic [MULT_W-1:0]  multiplier;
    logic [SHIFT_W-1:0] shift_amount;
    logic               add_fixup;
    logic               invalid;
  } mdg_out_t;

  // control of one shift-subtract lane
  typedef struct packed {
    logic clr;  // zero quotient and remainder
    logic en;   // take one step
    logic din;  // bit shifted into the remainder
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV0,
    ST_PREP,
    ST_DIV1,
    ST_SEARCH,
    ST_FINISH
  } mdg_state_e;

endpackage

`default_nettype wire

[design/mdg_lane.sv]
// One shift-subtract lane: quotient/remainder registers and a compare-subtract step.
// Depends on mdg_pkg. Serves both restoring division and the doubling search.
`default_nettype none

module mdg_lane #(
  parameter int WORD_BITS = mdg_pkg::WORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire mdg_pkg::lane_ctl_t    ctl_i,
  input  wire logic [WORD_BITS-1:0]  divisor_i,
  output logic      [WORD_BITS+1:0]  quo_o,
  output logic      [WORD_BITS-1:0]  rem_o
);
  import mdg_pkg::*;

  logic [WORD_BITS+1:0] quo_q, quo_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS:0]   rem_sh, rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, ctl_i.din};
    ge      = rem_sh >= {1'b0, divisor_i};
    rem_sub = rem_sh - {1'b0, divisor_i};
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (ctl_i.clr) begin
      quo_d = '0;
      rem_d = '0;
    end else if (ctl_i.en) begin
      quo_d = {quo_q[WORD_BITS:0], ge};
      // remainder stays below the divisor, so the top bit drops out
      rem_d = ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

[design/division_magic_number_generator_top.sv]
// Division magic-number generator, top level. Depends on mdg_pkg, mdg_lane and the
// assertion macro header. For a divisor d and a mode (opcode 0 unsigned, 1 signed) it
// returns the multiplier and post-shift that turn division by d into a high multiply and
// a right shift; in unsigned mode add_fixup marks a WORD_BITS+1 bit multiplier whose top
// bit is dropped. invalid flags a zero or too-wide unsigned divisor and a signed divisor
// outside 2..2^(WORD_BITS-1)-1; the other fields are then zero. One request is worked on
// at a time: lane A first runs a restoring division (one bit per cycle) for the remainder
// of 2^WORD_BITS or 2^(WORD_BITS-1) by d, then both lanes run a second pair of divisions
// in parallel, then the doubling search one step per cycle. The result sits in an output
// register, so a new request is taken while it waits.
`default_nettype none

`include "division_magic_number_generator_top_macros.svh"

module division_magic_number_generator_top #(
  parameter int WORD_BITS = mdg_pkg::WORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire mdg_pkg::mdg_in_t in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mdg_pkg::mdg_out_t     out_data_o
);
  import mdg_pkg::*;

  localparam int CNT_W = $clog2(2 * WORD_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_DIV_LAST = CNT_W'(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_P0       = CNT_W'(WORD_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_PMAX     = CNT_W'(2 * WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO      = CNT_W'(2);
  localparam logic [DIV_W:0]   FULL_X       = (DIV_W+1)'(1) << WORD_BITS;
  localparam logic [DIV_W:0]   HALF_X       = (DIV_W+1)'(1) << (WORD_BITS - 1);
  localparam logic [DIV_W:0]   TWO_X        = (DIV_W+1)'(2);
  localparam logic [WORD_BITS-1:0] HALF_M1  = WORD_BITS'(HALF_X - (DIV_W+1)'(1));

  mdg_state_e state_q, state_d;

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 op_q, bad_q;
  logic [WORD_BITS-1:0] d_q, nc_q, nc_d;
  logic                 out_valid_q, out_valid_d;
  mdg_out_t             out_q, res;

  logic                 accept, out_free, out_load, bad_in, srch_go, nc_load;
  logic [DIV_W:0]       div_x;
  lane_ctl_t            ctl_a, ctl_b;
  logic [WORD_BITS-1:0] dv_a;
  logic [WORD_BITS+1:0] quo_a, quo_b, mv;
  logic [WORD_BITS-1:0] rem_a, rem_b, delta;

  // lane A: remainder of the power of two, then q1/r1 over nc
  mdg_lane #(.WORD_BITS(WORD_BITS)) u_lane_a (
    .clk_i     (clk_i),
    .ctl_i     (ctl_a),
    .divisor_i (dv_a),
    .quo_o     (quo_a),
    .rem_o     (rem_a)
  );

  // lane B: q2/r2 over d
  mdg_lane #(.WORD_BITS(WORD_BITS)) u_lane_b (
    .clk_i     (clk_i),
    .ctl_i     (ctl_b),
    .divisor_i (d_q),
    .quo_o     (quo_b),
    .rem_o     (rem_b)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // range check on the raw divisor
  always_comb begin
    div_x = {1'b0, in_data_i.divisor};
    if (in_data_i.opcode == OP_SIGNED) begin
      bad_in = (div_x < TWO_X) || (div_x >= HALF_X);
    end else begin
      bad_in = (div_x == '0) || (div_x >= FULL_X);
    end
  end

  // search exit test on the registered step results
  always_comb begin
    delta   = (op_q == OP_SIGNED) ? d_q - rem_b : d_q - WORD_BITS'(1) - rem_b;
    srch_go = (cnt_q == CNT_P0) ||
              ((cnt_q < CNT_PMAX) &&
               ((quo_a < {2'b00, delta}) ||
                ((quo_a == {2'b00, delta}) && (rem_a == '0))));
  end

  // nc: largest value one below a multiple of d under the power of two
  assign nc_d = (op_q == OP_SIGNED) ? HALF_M1 - rem_a : ~rem_a;

  // result formatting
  always_comb begin
    mv  = quo_b + (WORD_BITS+2)'(1);
    res = '0;
    if (bad_q) begin
      res.invalid = 1'b1;
    end else begin
      res.multiplier   = MULT_W'(mv[WORD_BITS-1:0]);
      res.shift_amount = SHIFT_W'(cnt_q - CNT_DIV_LAST);
      res.add_fixup    = (op_q == OP_UNSIGNED) && (mv[WORD_BITS+1:WORD_BITS] != 2'b00);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = bad_in ? ST_FINISH : ST_DIV0;
      end
      ST_DIV0: begin
        if (cnt_q == CNT_DIV_LAST) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        if (cnt_q == CNT_DIV_LAST) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!srch_go) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    in_stall_o = 1'b1;
    ctl_a      = '0;
    ctl_b      = '0;
    dv_a       = nc_q;
    nc_load    = 1'b0;
    out_load   = 1'b0;
    cnt_d      = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl_a.clr  = 1'b1;
        cnt_d      = '0;
      end
      ST_DIV0: begin
        // dividend is 2^W (unsigned) or 2^(W-1) (signed), fed MSB first
        dv_a      = d_q;
        ctl_a.en  = 1'b1;
        ctl_a.din = (op_q == OP_SIGNED) ? (cnt_q == CNT_ONE) : (cnt_q == '0);
        cnt_d     = (cnt_q == CNT_DIV_LAST) ? '0 : cnt_q + CNT_ONE;
      end
      ST_PREP: begin
        nc_load   = 1'b1;
        ctl_a.clr = 1'b1;
        ctl_b.clr = 1'b1;
      end
      ST_DIV1: begin
        // A: 2^(W-1) / nc; B: (2^(W-1)-1) / d unsigned, 2^(W-1) / d signed
        ctl_a.en  = 1'b1;
        ctl_a.din = (cnt_q == CNT_ONE);
        ctl_b.en  = 1'b1;
        ctl_b.din = (op_q == OP_SIGNED) ? (cnt_q == CNT_ONE) : (cnt_q >= CNT_TWO);
        cnt_d     = (cnt_q == CNT_DIV_LAST) ? CNT_P0 : cnt_q + CNT_ONE;
      end
      ST_SEARCH: begin
        if (srch_go) begin
          ctl_a.en  = 1'b1;
          ctl_b.en  = 1'b1;
          ctl_b.din = (op_q == OP_UNSIGNED);
          cnt_d     = cnt_q + CNT_ONE;
        end
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // request and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_data_i.opcode;
      bad_q <= bad_in;
      d_q   <= in_data_i.divisor[WORD_BITS-1:0];
    end
    if (nc_load) nc_q <= nc_d;
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `MDG_ASSERT_NOW(a_invalid_zero, out_valid_o && out_data_o.invalid,
    (out_data_o.multiplier == '0) && (out_data_o.shift_amount == '0) &&
    !out_data_o.add_fixup, "invalid result carries nonzero fields")
  `MDG_ASSERT_NOW(a_shift_range, out_valid_o,
    out_data_o.shift_amount <= SHIFT_W'(WORD_BITS), "shift amount above word size")
  `MDG_ASSERT_NOW(a_search_bound, state_q == ST_SEARCH,
    (cnt_q >= CNT_P0) && (cnt_q <= CNT_PMAX), "search step count out of range")
  `MDG_ASSERT_NOW(a_rem_b_below_d, state_q == ST_SEARCH,
    rem_b < d_q, "q2 remainder not reduced below divisor")

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for division_magic_number_generator_top.
// Depends on mdg_pkg and the block's RTL. An internal predictor computes the expected
// multiplier, shift, add_fixup and invalid for each request, with random gaps and stalls.
`timescale 1ns / 100ps

module tb_top;
  import mdg_pkg::*;

  localparam int WB         = WORD_BITS_DEF;
  localparam int HALF_CLK   = 6;
  localparam int DRAIN_WAIT = 3 * WB + 20;  // worst accept-to-result latency plus margin
  localparam int MAX_SHOWN  = 10;

  // stall profiles for the result side
  typedef enum int {
    STALL_NONE,
    STALL_NORMAL,
    STALL_HEAVY
  } stall_mode_e;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  mdg_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  mdg_out_t out_data_o;

  mdg_out_t    magic_q[$];  // predicted results, oldest first
  int          mismatches;
  bit          sender_gaps;
  stall_mode_e stall_mode;
  int          stall_left;

  division_magic_number_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #HALF_CLK clk_i = ~clk_i;

  // Predictor: the published magic-number search, on 64-bit words wider than the block's
  // WORD_BITS, so intermediate values do not wrap around.
  function automatic mdg_out_t magic_for(input logic op, input logic [DIV_W-1:0] dv);
    bit [63:0] d;
    bit [63:0] full;
    bit [63:0] half;
    bit [63:0] nc;
    bit [63:0] q1;
    bit [63:0] r1;
    bit [63:0] q2;
    bit [63:0] r2;
    bit [63:0] delta;
    bit [63:0] mv;
    int        p;
    mdg_out_t  res;
    res  = '0;
    d    = 64'(dv);
    full = 64'd1 << WB;
    half = 64'd1 << (WB - 1);
    p    = WB - 1;
    if (op == OP_UNSIGNED) begin
      if (d == 64'd0 || d >= full) begin
        res.invalid = 1'b1;
      end else begin
        nc = full - 64'd1 - (full % d);
        q1 = half / nc;
        r1 = half - q1 * nc;
        q2 = (half - 64'd1) / d;
        r2 = (half - 64'd1) - q2 * d;
        do begin
          p++;
          q1 = q1 << 1;
          r1 = r1 << 1;
          if (r1 >= nc) begin
            q1++;
            r1 -= nc;
          end
          q2 = q2 << 1;
          r2 = (r2 << 1) + 64'd1;
          if (r2 >= d) begin
            q2++;
            r2 -= d;
          end
          delta = d - 64'd1 - r2;
        end while (p < 2 * WB && (q1 < delta || (q1 == delta && r1 == 64'd0)));
        mv               = q2 + 64'd1;
        res.shift_amount = SHIFT_W'(p - WB);
        if (mv >= full) begin
          res.add_fixup  = 1'b1;
          res.multiplier = MULT_W'((mv - full) & (full - 64'd1));
        end else begin
          res.multiplier = MULT_W'(mv);
        end
      end
    end else begin
      // signed: positive divisors 2 .. 2^(WB-1)-1 only
      if (d < 64'd2 || d >= half) begin
        res.invalid = 1'b1;
      end else begin
        nc = half - 64'd1 - (half % d);
        q1 = half / nc;
        r1 = half - q1 * nc;
        q2 = half / d;
        r2 = half - q2 * d;
        do begin
          p++;
          q1 = q1 << 1;
          r1 = r1 << 1;
          if (r1 >= nc) begin
            q1++;
            r1 -= nc;
          end
          q2 = q2 << 1;
          r2 = r2 << 1;
          if (r2 >= d) begin
            q2++;
            r2 -= d;
          end
          delta = d - r2;
        end while (p < 2 * WB && (q1 < delta || (q1 == delta && r1 == 64'd0)));
        res.multiplier   = MULT_W'((q2 + 64'd1) & (full - 64'd1));
        res.shift_amount = SHIFT_W'(p - WB);
      end
    end
    return res;
  endfunction

  // Sender idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!sender_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Divisor shapes that reach the interesting corners of the search: small values,
  // powers of two and neighbors, random widths, values near the top of each range.
  // Signed requests mostly keep bit 31 clear so that the search runs.
  function automatic logic [DIV_W-1:0] rand_divisor(input logic op);
    logic [DIV_W-1:0] v;
    int               k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = DIV_W'($urandom_range(1, 300));
      6: begin
        k = $urandom_range(0, DIV_W - 1);
        v = (DIV_W'(1) << k) + DIV_W'($urandom_range(0, 2)) - DIV_W'(1);
      end
      7: begin
        k = $urandom_range(1, DIV_W);
        v = $urandom & (DIV_W'({DIV_W{1'b1}}) >> (DIV_W - k));
      end
      8: begin
        if ($urandom_range(0, 1) == 0) v = 32'hFFFF_FFFF - DIV_W'($urandom_range(0, 500));
        else v = 32'h7FFF_FFFF - DIV_W'($urandom_range(0, 500));
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = DIV_W'(1);
          2:       v = 32'h8000_0000;
          default: v = $urandom | 32'h8000_0000;
        endcase
      end
    endcase
    if (op == OP_SIGNED && v > 32'd1 && $urandom_range(0, 99) < 85) v[DIV_W-1] = 1'b0;
    return v;
  endfunction

  // Drive one request, hold it until accepted, record the prediction, then maybe idle.
  // With no gap, valid simply stays high for the next request.
  task automatic send_request(input logic op, input logic [DIV_W-1:0] dv);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, divisor: dv};
    do @(posedge clk_i); while (in_stall_o);
    magic_q.push_back(magic_for(op, dv));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic lower_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 1) == 0) ? OP_UNSIGNED : OP_SIGNED;
      send_request(op, rand_divisor(op));
    end
  endtask

  // --- tests -------------------------------------------------------------------------

  // zero, one, small odd/even, 7 (needs the add step), 641, and both ends of the word
  task automatic test_unsigned_edges();
    logic [DIV_W-1:0] vals[$] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10,
                                  32'd641, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                                  32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (vals[i]) send_request(OP_UNSIGNED, vals[i]);
  endtask

  // below range, lowest legal, mid values, top legal, and above range (sign bit set)
  task automatic test_signed_edges();
    logic [DIV_W-1:0] vals[$] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd7, 32'h4000_0000,
                                  32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF};
    foreach (vals[i]) send_request(OP_SIGNED, vals[i]);
  endtask

  task automatic test_random_mix();
    sender_gaps = 1'b1;
    stall_mode  = STALL_NORMAL;
    send_random(1050);
  endtask

  // no idling on either side: request taken while the previous result waits
  task automatic test_back_to_back();
    sender_gaps = 1'b0;
    stall_mode  = STALL_NONE;
    send_random(300);
  endtask

  // sender holds off until every pending result is back, several times
  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    stall_mode  = STALL_NORMAL;
    for (int round = 0; round < 4; round++) begin
      send_random(40);
      lower_valid();
      wait (magic_q.size() == 0);
      @(posedge clk_i);
    end
  endtask

  task automatic test_receiver_backpressure();
    sender_gaps = 1'b1;
    stall_mode  = STALL_HEAVY;
    send_random(250);
  endtask

  // --- result side -------------------------------------------------------------------

  // Stall generator: runs of free and stalled cycles; profile set by the running test.
  always @(posedge clk_i) begin
    if (stall_mode == STALL_NONE) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall_i <= 1'b1;
          stall_left = $urandom_range(10, 40);
        end
        1, 2, 3, 4, 5, 6: begin
          out_stall_i <= 1'b1;
          stall_left = (stall_mode == STALL_HEAVY) ? $urandom_range(3, 25)
                                                   : $urandom_range(0, 2);
        end
        default: begin
          out_stall_i <= 1'b0;
          stall_left = $urandom_range(0, 8);
        end
      endcase
    end
  end

  // Checker: each accepted result against the oldest prediction, field by field.
  always @(posedge clk_i) begin
    mdg_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (magic_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] result with no pending request: mult=%h shift=%0d add=%b inv=%b",
                   $realtime, out_data_o.multiplier, out_data_o.shift_amount,
                   out_data_o.add_fixup, out_data_o.invalid);
      end else begin
        want = magic_q.pop_front();
        if (out_data_o.multiplier   !== want.multiplier   ||
            out_data_o.shift_amount !== want.shift_amount ||
            out_data_o.add_fixup    !== want.add_fixup    ||
            out_data_o.invalid      !== want.invalid) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] exp m=%h s=%0d a=%b i=%b, got m=%h s=%0d a=%b i=%b",
                     $realtime, want.multiplier, want.shift_amount, want.add_fixup,
                     want.invalid, out_data_o.multiplier, out_data_o.shift_amount,
                     out_data_o.add_fixup, out_data_o.invalid);
        end
      end
    end
  end

  // --- sequence ----------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    stall_left  = 0;
    sender_gaps = 1'b1;
    stall_mode  = STALL_NORMAL;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unsigned_edges();
    test_signed_edges();
    test_random_mix();
    test_back_to_back();
    test_drain_pause();
    test_receiver_backpressure();

    // all requests are in; let the last results come out, then a latency's worth more
    lower_valid();
    wait (magic_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && magic_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #24_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
